>>> design/int_to_ascii_digits_defines.svh
// Assertion macros shared by the int_to_ascii_digits RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef INT_TO_ASCII_DIGITS_DEFINES_SVH
`define INT_TO_ASCII_DIGITS_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define I2A_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
        else $error("int_to_ascii_digits: same-cycle check failed");

// Antecedent implies consequent in the following cycle.
`define I2A_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
        else $error("int_to_ascii_digits: next-cycle check failed");

`endif

>>> design/i2a_pkg.sv
// Shared types, constants and the digit character table for int_to_ascii_digits.
// No dependencies; imported by i2a_cell and the top level.
`timescale 1ns / 1ps

package i2a_pkg;

    localparam int VALUE_W     = 32;
    localparam int FUNC_W      = 2;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 4;
    localparam int NUM_DIGITS  = 10;
    localparam int REM_W       = $clog2(NUM_DIGITS + 1);
    localparam int SHIFT_CNT_W = $clog2(VALUE_W);

    // Mode encodings of the func field. Bit one selects base sixteen.
    localparam logic [FUNC_W-1:0] FUNC_SDEC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_UDEC = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_HEX  = 2'd2;
    localparam int FUNC_HEX_BIT = 1;

    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

    localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_CLEAR  = 2'd1,
        CELL_DABBLE = 2'd2,
        CELL_MOVE   = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     dec;
    } cell_ctrl_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        return DIGIT_CHARS[d];
    endfunction

endpackage

>>> design/i2a_cell.sv
// One digit cell of the conversion chain: a four-bit digit with shift-and-add-3 step.
// Depends on i2a_pkg for the cell control struct.
`timescale 1ns / 1ps

module i2a_cell
    import i2a_pkg::*;
(
    input  logic               clk,
    input  cell_ctrl_t         ctrl,
    input  logic               carry_in,
    input  logic [DIGIT_W-1:0] digit_in,
    output logic               carry_out,
    output logic [DIGIT_W-1:0] digit
);

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [DIGIT_W-1:0] corr;

    // In decimal mode a digit of five or more is bumped by three before the shift.
    always_comb
    begin
        corr = (ctrl.dec && (digit_reg >= 4'd5)) ? (digit_reg + 4'd3) : digit_reg;
        unique case (ctrl.op)
            CELL_HOLD:   digit_next = digit_reg;
            CELL_CLEAR:  digit_next = '0;
            CELL_DABBLE: digit_next = {corr[DIGIT_W-2:0], carry_in};
            CELL_MOVE:   digit_next = digit_in;
            default:     digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign carry_out = corr[DIGIT_W-1];
    assign digit     = digit_reg;

endmodule

>>> design/int_to_ascii_digits.sv
// Top level of int_to_ascii_digits: control sequencer, digit cell chain, output register.
// Depends on i2a_pkg, i2a_cell and int_to_ascii_digits_defines.svh.
`timescale 1ns / 1ps
`include "int_to_ascii_digits_defines.svh"

// Usage
// A request on the input channel (in_valid/in_ready) carries a 32-bit value and
// a mode in func: signed decimal, unsigned decimal, or lower-case hexadecimal.
// The block answers with one output request per character (out_valid/out_ready),
// most significant character first, with last set on the final one. A negative
// signed value starts with a minus sign; zero gives a single '0'.
// Timing: the value is shifted one bit per cycle through a chain of ten digit
// cells, then leading zero digits are dropped one per cycle, then one character
// leaves per cycle while the receiver is ready. One number is in work at a
// time; in_ready is high only while the sequencer is idle.
// The output register holds a character until it is taken, so a stalled receiver
// holds the sequencer in its sign and emit states, while a new input request can
// still be taken once the final character sits in that register.
// Reset (rst_n, asynchronous, active low) returns the sequencer to idle and
// empties the output register; no other state needs clearing.

module int_to_ascii_digits
    import i2a_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [VALUE_W-1:0]  value,
    input  logic [FUNC_W-1:0]   func,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [CHAR_W-1:0]   char_out,
    output logic                last
);

    // One-hot sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CONV = 5'b00010,
        ST_SKIP = 5'b00100,
        ST_SIGN = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [VALUE_W-1:0]     bin_reg, bin_next;
    logic [SHIFT_CNT_W-1:0] cnt_reg, cnt_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic                   neg_reg, neg_next;
    logic                   dec_reg, dec_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]      char_reg, char_next;
    logic                   last_reg, last_next;

    cell_ctrl_t             cell_ctrl;
    logic [DIGIT_W-1:0]     dig   [NUM_DIGITS];
    logic                   carry [NUM_DIGITS+1];
    logic [DIGIT_W-1:0]     top_digit;
    logic                   slot_free;
    logic                   in_take;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_take   = in_valid && in_ready;
    // The output register can take a character when empty or being drained.
    assign slot_free = !out_valid_reg || out_ready;
    assign top_digit = dig[NUM_DIGITS-1];
    assign carry[0]  = bin_reg[VALUE_W-1];

    // Digit chain: cell 0 takes the next binary bit, each cell hands its
    // overflow bit upward while converting and its digit upward while skipping and emitting.
    for (genvar k = 0; k < NUM_DIGITS; k++)
    begin : g_cells
        logic [DIGIT_W-1:0] below;
        if (k == 0)
        begin : g_first
            assign below = '0;
        end
        else
        begin : g_rest
            assign below = dig[k-1];
        end
        i2a_cell u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl),
            .carry_in  (carry[k]),
            .digit_in  (below),
            .carry_out (carry[k+1]),
            .digit     (dig[k])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        dec_next       = dec_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cell_ctrl.op   = CELL_HOLD;
        cell_ctrl.dec  = dec_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    // Signed mode with the sign bit set: convert the magnitude.
                    neg_next     = (func == FUNC_SDEC) && value[VALUE_W-1];
                    bin_next     = ((func == FUNC_SDEC) && value[VALUE_W-1]) ?
                                   (~value + 1'b1) : value;
                    dec_next     = !func[FUNC_HEX_BIT];
                    cnt_next     = SHIFT_CNT_W'(VALUE_W - 1);
                    cell_ctrl.op = CELL_CLEAR;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cell_ctrl.op = CELL_DABBLE;
                bin_next     = {bin_reg[VALUE_W-2:0], 1'b0};
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    rem_next   = REM_W'(NUM_DIGITS);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // Drop leading zeros but always keep the final digit.
                if ((top_digit == '0) && (rem_reg > REM_W'(1)))
                begin
                    cell_ctrl.op = CELL_MOVE;
                    rem_next     = rem_reg - 1'b1;
                end
                else
                begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    char_next      = ASCII_MINUS;
                    last_next      = 1'b0;
                    out_valid_next = 1'b1;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    char_next      = digit_char(top_digit);
                    last_next      = (rem_reg == REM_W'(1));
                    out_valid_next = 1'b1;
                    cell_ctrl.op   = CELL_MOVE;
                    rem_next       = rem_reg - 1'b1;
                    if (rem_reg == REM_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        dec_reg  <= dec_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign char_out  = char_reg;
    assign last      = last_reg;

    // The final digit of a number is loaded with last set.
    `I2A_ASSERT_NEXT(a_last_on_final, clk, rst_n,
        (state_reg == ST_EMIT) && slot_free && (rem_reg == REM_W'(1)),
        out_valid_reg && last_reg && (state_reg == ST_IDLE))
    // While emitting there is always at least one digit left.
    `I2A_ASSERT_SAME(a_emit_rem_nonzero, clk, rst_n,
        state_reg == ST_EMIT, rem_reg != '0)
    // Hexadecimal conversion never spills into the two upper cells.
    `I2A_ASSERT_SAME(a_hex_upper_clear, clk, rst_n,
        (state_reg == ST_SKIP) && !dec_reg && (rem_reg == REM_W'(NUM_DIGITS)),
        (dig[NUM_DIGITS-1] == '0) && (dig[NUM_DIGITS-2] == '0))

endmodule
